// ===== rtl/core/texture_page_valid_tracker_macros.svh =====
// assertion macros for the texture page valid tracker
// expects clk_i and rst_ni in the scope of use
`ifndef TEXTURE_PAGE_VALID_TRACKER_MACROS_SVH
`define TEXTURE_PAGE_VALID_TRACKER_MACROS_SVH

// same-cycle implication
`define TPVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TPVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tpvt_pkg.sv =====
// shared types and constants of the texture page valid tracker
// no dependencies
package tpvt_pkg;

  localparam int PAGE_COLUMNS  = 16;
  localparam int PAGE_ROWS     = 2;
  localparam int NUM_FORMATS   = 3;
  localparam int COL_HALFWORDS = 64;
  localparam int ROW_LINES     = 256;

  // 12 bits hold every bound and page end without overflow
  localparam int CMP_W = 12;

  localparam logic [CMP_W-1:0] TABLE_SPAN_SMALL = 12'd16;
  localparam logic [CMP_W-1:0] TABLE_SPAN_LARGE = 12'd256;
  localparam logic [8:0]       ENTRIES_4BIT     = 9'd16;
  localparam logic [8:0]       ENTRIES_8BIT     = 9'd256;

  typedef enum logic [1:0] {
    KIND_PAGE  = 2'd0,
    KIND_TABLE = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FMT_4BIT  = 2'd0,
    FMT_8BIT  = 2'd1,
    FMT_16BIT = 2'd2,
    FMT_NONE  = 2'd3
  } format_e;

  typedef struct packed {
    kind_e       kind;
    format_e     format;
    logic [3:0]  page_col;
    logic        page_row;
    logic [5:0]  table_col;
    logic [8:0]  table_row;
    logic [10:0] rect_left;
    logic [9:0]  rect_top;
    logic [10:0] rect_right;
    logic [9:0]  rect_bottom;
  } item_t;

  typedef struct packed {
    logic reload;
    logic rejected;
  } page_res_t;

  typedef struct packed {
    logic       reload;
    logic [8:0] entries;
  } table_res_t;

endpackage

// ===== rtl/core/texture_page_valid_tracker.sv =====
// Texture page valid tracker: input register, page grid and colour table tag
// logic, result register. Each item is registered in the input register, then in the
// result register; throughput one item per cycle while the result register is free
// or being drained. Reset clears all page valid bits, marks the colour table dirty
// and zeroes its tag; both pipeline stages come up empty.
// depends on tpvt_pkg, tpvt_page_grid, tpvt_clut_tag and the macros header
`include "texture_page_valid_tracker_macros.svh"

module texture_page_valid_tracker import tpvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  format_i,
  input  logic [3:0]  page_col_i,
  input  logic        page_row_i,
  input  logic [5:0]  table_col_i,
  input  logic [8:0]  table_row_i,
  input  logic [10:0] rect_left_i,
  input  logic [9:0]  rect_top_i,
  input  logic [10:0] rect_right_i,
  input  logic [9:0]  rect_bottom_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        reload_o,
  output logic        rejected_o,
  output logic [8:0]  table_entries_o
);

  logic       s1_valid_q;
  item_t      s1_item_q;
  logic       s1_adv;
  logic       in_xfer;
  page_res_t  page_res;
  table_res_t table_res;

  logic       out_valid_q;
  logic       reload_q, rejected_q;
  logic [8:0] entries_q;

  // stage 1 moves on when the result register is free or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= '{kind:        kind_e'(kind_i),
                     format:      format_e'(format_i),
                     page_col:    page_col_i,
                     page_row:    page_row_i,
                     table_col:   table_col_i,
                     table_row:   table_row_i,
                     rect_left:   rect_left_i,
                     rect_top:    rect_top_i,
                     rect_right:  rect_right_i,
                     rect_bottom: rect_bottom_i};
    end
  end

  tpvt_page_grid u_page_grid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .item_i (s1_item_q),
    .res_o  (page_res)
  );

  tpvt_clut_tag u_clut_tag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .item_i (s1_item_q),
    .res_o  (table_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      reload_q   <= page_res.reload | table_res.reload;
      rejected_q <= page_res.rejected;
      entries_q  <= table_res.entries;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reload_o        = reload_q;
  assign rejected_o      = rejected_q;
  assign table_entries_o = entries_q;

  `TPVT_ASSERT_NOW(a_stall_needs_item, in_stall_o, s1_valid_q, "stall with empty input stage")
  `TPVT_ASSERT_NEXT(a_held_item_stays, s1_valid_q && !s1_adv, s1_valid_q, "held item lost")
  `TPVT_ASSERT_NOW(a_reject_alone, out_valid_o && rejected_o,
                   !reload_o && table_entries_o == '0, "rejected result carries reload data")
  `TPVT_ASSERT_NOW(a_entries_need_reload, out_valid_o && table_entries_o != '0, reload_o,
                   "table entries without reload")

endmodule

// ===== rtl/core/tpvt_page_grid.sv =====
// page valid bits per format, row and column, with lookup and rectangle clear
// depends on tpvt_pkg
module tpvt_page_grid import tpvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  item_t     item_i,
  output page_res_t res_o
);

  logic [PAGE_COLUMNS-1:0] valid_q [NUM_FORMATS][PAGE_ROWS];
  logic [PAGE_COLUMNS-1:0] valid_d [NUM_FORMATS][PAGE_ROWS];
  logic                    in_grid;
  logic [CMP_W-1:0]        left, right, top, bottom;

  assign in_grid = (int'(item_i.page_col) < PAGE_COLUMNS) &&
                   (int'(item_i.page_row) < PAGE_ROWS);
  assign left    = CMP_W'(item_i.rect_left);
  assign right   = CMP_W'(item_i.rect_right);
  assign top     = CMP_W'(item_i.rect_top);
  assign bottom  = CMP_W'(item_i.rect_bottom);

  always_comb begin
    valid_d = valid_q;
    res_o   = '0;
    case (item_i.kind)
      KIND_PAGE: begin
        if (item_i.format == FMT_NONE) begin
          res_o.rejected = 1'b1;
        end else if (!in_grid) begin
          res_o.reload = 1'b1;
        end else begin
          for (int f = 0; f < NUM_FORMATS; f++) begin
            for (int r = 0; r < PAGE_ROWS; r++) begin
              for (int c = 0; c < PAGE_COLUMNS; c++) begin
                if (item_i.format == format_e'(2'(f)) && int'(item_i.page_row) == r &&
                    int'(item_i.page_col) == c && !valid_q[f][r][c]) begin
                  res_o.reload     = 1'b1;
                  valid_d[f][r][c] = 1'b1;
                end
              end
            end
          end
        end
      end
      KIND_WRITE: begin
        for (int r = 0; r < PAGE_ROWS; r++) begin
          for (int c = 0; c < PAGE_COLUMNS; c++) begin
            for (int f = 0; f < NUM_FORMATS; f++) begin
              // page spans 64 << format columns from its start
              if (CMP_W'(r * ROW_LINES) < bottom &&
                  top < CMP_W'(r * ROW_LINES + ROW_LINES) &&
                  CMP_W'(c * COL_HALFWORDS) < right &&
                  left < CMP_W'(c * COL_HALFWORDS + (COL_HALFWORDS << f))) begin
                valid_d[f][r][c] = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < NUM_FORMATS; f++) begin
        for (int r = 0; r < PAGE_ROWS; r++) begin
          valid_q[f][r] <= '0;
        end
      end
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

endmodule

// ===== rtl/core/tpvt_clut_tag.sv =====
// colour table tag and dirty mark, table lookup and write coverage check
// depends on tpvt_pkg
module tpvt_clut_tag import tpvt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  item_t      item_i,
  output table_res_t res_o
);

  logic       dirty_q, dirty_d;
  format_e    fmt_q, fmt_d;
  logic [5:0] x_q, x_d;
  logic [8:0] y_q, y_d;

  logic             miss;
  logic [CMP_W-1:0] tl, tr;

  assign miss = dirty_q || fmt_q != item_i.format || x_q != item_i.table_col ||
                y_q != item_i.table_row;
  assign tl   = CMP_W'({x_q, 4'b0000});
  assign tr   = tl + ((fmt_q == FMT_4BIT) ? TABLE_SPAN_SMALL : TABLE_SPAN_LARGE);

  always_comb begin
    dirty_d = dirty_q;
    fmt_d   = fmt_q;
    x_d     = x_q;
    y_d     = y_q;
    res_o   = '0;
    case (item_i.kind)
      KIND_TABLE: begin
        if (miss) begin
          res_o.reload = 1'b1;
          case (item_i.format)
            FMT_4BIT: res_o.entries = ENTRIES_4BIT;
            FMT_8BIT: res_o.entries = ENTRIES_8BIT;
            default:  res_o.entries = '0;
          endcase
          dirty_d = 1'b0;
          fmt_d   = item_i.format;
          x_d     = item_i.table_col;
          y_d     = item_i.table_row;
        end
      end
      KIND_WRITE: begin
        if (!dirty_q && CMP_W'(item_i.rect_top) <= CMP_W'(y_q) &&
            CMP_W'(y_q) < CMP_W'(item_i.rect_bottom) &&
            CMP_W'(item_i.rect_left) < tr && CMP_W'(item_i.rect_right) > tl) begin
          dirty_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b1;
      fmt_q   <= FMT_4BIT;
      x_q     <= '0;
      y_q     <= '0;
    end else if (en_i) begin
      dirty_q <= dirty_d;
      fmt_q   <= fmt_d;
      x_q     <= x_d;
      y_q     <= y_d;
    end
  end

endmodule

// ===== dv/texture_page_valid_tracker_check.sv =====
`timescale 1ns / 100ps
// result checker for the texture page valid tracker: keeps its own page grid and
// colour table tag, predicts every input transfer and compares the output transfers
// depends on tpvt_pkg
module texture_page_valid_tracker_check import tpvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [1:0]  format_i,
  input  logic [3:0]  page_col_i,
  input  logic        page_row_i,
  input  logic [5:0]  table_col_i,
  input  logic [8:0]  table_row_i,
  input  logic [10:0] rect_left_i,
  input  logic [9:0]  rect_top_i,
  input  logic [10:0] rect_right_i,
  input  logic [9:0]  rect_bottom_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        reload_i,
  input  logic        rejected_i,
  input  logic [8:0]  table_entries_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o,
  output int          reload_count_o,
  output int          reject_count_o,
  output int          backup_cycles_o
);

  typedef struct packed {
    logic       reload;
    logic       rejected;
    logic [8:0] entries;
  } tracker_result_t;

  // page valid bits, indexed format * PAGE_ROWS + row
  logic [15:0] valid_bits [NUM_FORMATS*PAGE_ROWS];
  logic        clut_dirty;
  logic [1:0]  clut_format;
  logic [5:0]  clut_x;
  logic [8:0]  clut_y;

  tracker_result_t expected_results [$];

  int mismatches    = 0;
  int results_seen  = 0;
  int reloads_seen  = 0;
  int rejects_seen  = 0;
  int backup_cycles = 0;

  assign fail_count_o    = mismatches;
  assign pending_o       = expected_results.size();
  assign result_count_o  = results_seen;
  assign reload_count_o  = reloads_seen;
  assign reject_count_o  = rejects_seen;
  assign backup_cycles_o = backup_cycles;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // updates the tracked state and returns what the block must answer
  function automatic tracker_result_t predict_result(
    input logic [1:0] kind,
    input logic [1:0] fmt,
    input logic [3:0] pcol,
    input logic       prow,
    input logic [5:0] tcol,
    input logic [8:0] trow,
    input int         left,
    input int         top,
    input int         right,
    input int         bottom
  );
    tracker_result_t res;
    int idx, tl, tr, x, y, row, col, f;
    res = '0;
    case (kind)
      KIND_PAGE: begin
        if (fmt == FMT_NONE) begin
          res.rejected = 1'b1;
        end else if (int'(pcol) >= PAGE_COLUMNS || int'(prow) >= PAGE_ROWS) begin
          res.reload = 1'b1;
        end else begin
          idx = int'(fmt) * PAGE_ROWS + int'(prow);
          if (!valid_bits[idx][pcol]) begin
            res.reload = 1'b1;
            valid_bits[idx][pcol] = 1'b1;
          end
        end
      end
      KIND_TABLE: begin
        if (clut_dirty || clut_format != fmt || clut_x != tcol || clut_y != trow) begin
          res.reload  = 1'b1;
          res.entries = (fmt == FMT_4BIT) ? ENTRIES_4BIT :
                        (fmt == FMT_8BIT) ? ENTRIES_8BIT : 9'd0;
          clut_format = fmt;
          clut_x      = tcol;
          clut_y      = trow;
          clut_dirty  = 1'b0;
        end
      end
      KIND_WRITE: begin
        // table check only matters while the table is clean
        if (!clut_dirty && top <= int'(clut_y) && int'(clut_y) < bottom) begin
          tl = int'(clut_x) * 16;
          tr = tl + ((clut_format == FMT_4BIT) ? 16 : 256);
          if (left < tr && right > tl) clut_dirty = 1'b1;
        end
        for (row = 0; row < PAGE_ROWS; row++) begin
          y = row * ROW_LINES;
          if (y < bottom && top < y + ROW_LINES) begin
            for (col = 0; col < PAGE_COLUMNS; col++) begin
              x = col * COL_HALFWORDS;
              for (f = 0; f < NUM_FORMATS; f++) begin
                if (x < right && left < x + (COL_HALFWORDS << f))
                  valid_bits[f * PAGE_ROWS + row][col] = 1'b0;
              end
            end
          end
        end
      end
      default: ;  // unused kind answers with all zero
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tracker_result_t want;
    if (!rst_ni) begin
      foreach (valid_bits[i]) valid_bits[i] = '0;
      clut_dirty  = 1'b1;
      clut_format = FMT_4BIT;
      clut_x      = '0;
      clut_y      = '0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(predict_result(kind_i, format_i, page_col_i, page_row_i,
          table_col_i, table_row_i, int'(rect_left_i), int'(rect_top_i),
          int'(rect_right_i), int'(rect_bottom_i)));
      end
      if (in_valid_i && in_stall_i) backup_cycles++;
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        if (reload_i === 1'b1) reloads_seen++;
        if (rejected_i === 1'b1) rejects_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (reload_i !== want.reload)
            report_mismatch("reload", int'(reload_i), int'(want.reload));
          if (rejected_i !== want.rejected)
            report_mismatch("rejected", int'(rejected_i), int'(want.rejected));
          if (table_entries_i !== want.entries)
            report_mismatch("table_entries", int'(table_entries_i), int'(want.entries));
        end
      end
    end
  end

endmodule

// ===== dv/texture_page_valid_tracker_test.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the texture page valid tracker: directed lookups and
// writes, then random traffic with idle gaps and a long output hold-off
// depends on tpvt_pkg, texture_page_valid_tracker and texture_page_valid_tracker_check
module texture_page_valid_tracker_test;
  import tpvt_pkg::*;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AFTER   = 150;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_LIMIT  = 5000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  fmt;
    logic [3:0]  pcol;
    logic        prow;
    logic [5:0]  tcol;
    logic [8:0]  trow;
    logic [10:0] left;
    logic [9:0]  top;
    logic [10:0] right;
    logic [9:0]  bottom;
  } tracker_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [1:0]  fmt;
  logic [3:0]  page_col;
  logic        page_row;
  logic [5:0]  table_col;
  logic [8:0]  table_row;
  logic [10:0] rect_left;
  logic [9:0]  rect_top;
  logic [10:0] rect_right;
  logic [9:0]  rect_bottom;
  logic        out_valid;
  logic        out_stall;
  logic        reload;
  logic        rejected;
  logic [8:0]  table_entries;

  int fail_count, pending, result_count, reload_count, reject_count, backup_cycles;

  int   sent_count    = 0;
  logic sender_steady = 1'b0;
  logic long_hold_on  = 1'b0;
  logic [1:0] last_tfmt = FMT_4BIT;
  logic [5:0] last_tcol = '0;
  logic [8:0] last_trow = '0;

  texture_page_valid_tracker u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .format_i        (fmt),
    .page_col_i      (page_col),
    .page_row_i      (page_row),
    .table_col_i     (table_col),
    .table_row_i     (table_row),
    .rect_left_i     (rect_left),
    .rect_top_i      (rect_top),
    .rect_right_i    (rect_right),
    .rect_bottom_i   (rect_bottom),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .reload_o        (reload),
    .rejected_o      (rejected),
    .table_entries_o (table_entries)
  );

  texture_page_valid_tracker_check u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .kind_i          (kind),
    .format_i        (fmt),
    .page_col_i      (page_col),
    .page_row_i      (page_row),
    .table_col_i     (table_col),
    .table_row_i     (table_row),
    .rect_left_i     (rect_left),
    .rect_top_i      (rect_top),
    .rect_right_i    (rect_right),
    .rect_bottom_i   (rect_bottom),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .reload_i        (reload),
    .rejected_i      (rejected),
    .table_entries_i (table_entries),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .result_count_o  (result_count),
    .reload_count_o  (reload_count),
    .reject_count_o  (reject_count),
    .backup_cycles_o (backup_cycles)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly zero or short, now and then long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // every field random, including the ones the kind does not use
  function automatic tracker_req_t noise_req();
    tracker_req_t r;
    r.kind   = 2'($urandom_range(0, 3));
    r.fmt    = 2'($urandom_range(0, 3));
    r.pcol   = 4'($urandom_range(0, 15));
    r.prow   = 1'($urandom_range(0, 1));
    r.tcol   = 6'($urandom_range(0, 63));
    r.trow   = 9'($urandom_range(0, 511));
    r.left   = 11'($urandom_range(0, 2047));
    r.top    = 10'($urandom_range(0, 1023));
    r.right  = 11'($urandom_range(0, 2047));
    r.bottom = 10'($urandom_range(0, 1023));
    return r;
  endfunction

  function automatic tracker_req_t page_req(input logic [1:0] f, input int col, input int row);
    tracker_req_t r;
    r = noise_req();
    r.kind = KIND_PAGE;
    r.fmt  = f;
    r.pcol = 4'(col);
    r.prow = 1'(row);
    return r;
  endfunction

  function automatic tracker_req_t table_req(input logic [1:0] f, input int col, input int row);
    tracker_req_t r;
    r = noise_req();
    r.kind = KIND_TABLE;
    r.fmt  = f;
    r.tcol = 6'(col);
    r.trow = 9'(row);
    return r;
  endfunction

  function automatic tracker_req_t write_req(input int l, input int t, input int rt, input int b);
    tracker_req_t r;
    r = noise_req();
    r.kind   = KIND_WRITE;
    r.left   = 11'(l);
    r.top    = 10'(t);
    r.right  = 11'(rt);
    r.bottom = 10'(b);
    return r;
  endfunction

  function automatic tracker_req_t random_req();
    tracker_req_t r;
    int p, l, t, tl;
    p = $urandom_range(0, 99);
    if (p < 40) begin
      r = page_req(($urandom_range(0, 9) == 0) ? FMT_NONE : 2'($urandom_range(0, 2)),
                   $urandom_range(0, 15), $urandom_range(0, 1));
    end else if (p < 64) begin
      // half of the table lookups repeat the last tag so that hits happen
      if ($urandom_range(0, 1))
        r = table_req(last_tfmt, int'(last_tcol), int'(last_trow));
      else
        r = table_req(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 511));
    end else if (p < 96) begin
      p = $urandom_range(0, 99);
      if (p < 60) begin
        l = $urandom_range(0, 1023);
        t = $urandom_range(0, 511);
        r = write_req(l, t, (l + $urandom_range(1, 400) > 1024) ? 1024 : l + $urandom_range(1, 400),
                      (t + $urandom_range(1, 300) > 512) ? 512 : t + $urandom_range(1, 300));
      end else if (p < 80) begin
        // around the current table so that its dirty mark is hit and missed
        tl = int'(last_tcol) * 16;
        l  = tl - $urandom_range(0, 24);
        t  = int'(last_trow) - $urandom_range(0, 3);
        r  = write_req((l < 0) ? 0 : l, (t < 0) ? 0 : t, tl + $urandom_range(0, 40),
                       int'(last_trow) + $urandom_range(0, 2));
      end else begin
        r = write_req($urandom_range(0, 2047), $urandom_range(0, 1023),
                      $urandom_range(0, 2047), $urandom_range(0, 1023));
      end
    end else begin
      r = noise_req();
      r.kind = KIND_IGNORED;
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_req(input tracker_req_t r);
    int gap;
    gap = (sender_steady || long_hold_on) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind        <= r.kind;
    fmt         <= r.fmt;
    page_col    <= r.pcol;
    page_row    <= r.prow;
    table_col   <= r.tcol;
    table_row   <= r.trow;
    rect_left   <= r.left;
    rect_top    <= r.top;
    rect_right  <= r.right;
    rect_bottom <= r.bottom;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (r.kind == KIND_TABLE) begin
      last_tfmt = r.fmt;
      last_tcol = r.tcol;
      last_trow = r.trow;
    end
    @(negedge clk);
  endtask

  // receiver side: random stalls, quiet stretches and one long hold-off
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (!hold_done && sent_count >= HOLD_AFTER) begin
        long_hold_on = 1'b1;
        out_stall   <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_on = 1'b0;
        hold_done    = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 80)) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (1 + idle_len()) @(negedge clk);
      end
    end
  end

  initial begin
    int n;
    in_valid    = 1'b0;
    kind        = KIND_PAGE;
    fmt         = FMT_4BIT;
    page_col    = '0;
    page_row    = 1'b0;
    table_col   = '0;
    table_row   = '0;
    rect_left   = '0;
    rect_top    = '0;
    rect_right  = '0;
    rect_bottom = '0;
    rst_n       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // page miss then hit, format 3 rejection, grid corners
    send_req(page_req(FMT_4BIT, 0, 0));
    send_req(page_req(FMT_4BIT, 0, 0));
    send_req(page_req(FMT_NONE, 5, 1));
    send_req(page_req(FMT_16BIT, 15, 1));
    send_req(page_req(FMT_8BIT, 7, 0));
    send_req(page_req(FMT_16BIT, 15, 1));
    // table: dirty after reset, hit, tag changes, formats without entries
    send_req(table_req(FMT_4BIT, 0, 0));
    send_req(table_req(FMT_4BIT, 0, 0));
    send_req(table_req(FMT_8BIT, 63, 511));
    send_req(table_req(FMT_16BIT, 63, 511));
    send_req(table_req(FMT_NONE, 5, 100));
    send_req(table_req(FMT_4BIT, 2, 300));
    // write over the table dirties it, an adjacent one does not
    send_req(write_req(32, 300, 48, 301));
    send_req(table_req(FMT_4BIT, 2, 300));
    send_req(write_req(48, 300, 64, 301));
    send_req(table_req(FMT_4BIT, 2, 300));
    // empty, inverted, full and out of range rectangles
    send_req(write_req(100, 0, 100, 512));
    send_req(write_req(1024, 0, 0, 512));
    send_req(write_req(0, 0, 1024, 512));
    send_req(page_req(FMT_4BIT, 0, 0));
    send_req(write_req(2047, 1023, 2047, 1023));
    send_req(page_req(FMT_16BIT, 0, 1));
    send_req(write_req(0, 256, 64, 257));
    send_req(page_req(FMT_16BIT, 0, 1));
    send_req(noise_req());

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) sender_steady = ($urandom_range(0, 3) == 0);
      send_req(random_req());
    end
    in_valid <= 1'b0;

    n = 0;
    while (pending != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);

    $display("checked %0d results: %0d reloads, %0d rejected page lookups",
             result_count, reload_count, reject_count);
    $display("input held back for %0d cycles by a full pipeline", backup_cycles);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("run did not finish in time");
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== texture_page_valid_tracker.f =====
+incdir+rtl/core
rtl/core/tpvt_pkg.sv
rtl/core/tpvt_page_grid.sv
rtl/core/tpvt_clut_tag.sv
rtl/core/texture_page_valid_tracker.sv
dv/texture_page_valid_tracker_check.sv
dv/texture_page_valid_tracker_test.sv
